// ===== hw/rtl/bst_pkg.sv =====
// Shared constants and types for the bit-split trie builder.
package bst_pkg;
  localparam int MODULES_DEF = 4;
  localparam int TILES_DEF = 4;
  localparam int NODES_DEF = 256;
  localparam int MAX_WORD_DEF = 13;
  localparam int WORDS_PER_MODULE_DEF = 24;

  localparam int SYM_W = 8;
  localparam int PTR_W = 8;
  localparam int MV_W = 24;
  localparam int SEL_W = 2;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_ALL_FULL = 2'd2,
    ST_NODES_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic              func;
    logic [SYM_W-1:0]  symbol;
    logic              last;
    logic [SEL_W-1:0]  module_sel;
    logic [SEL_W-1:0]  tile_sel;
    logic [PTR_W-1:0]  node_idx;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SEL_W-1:0]  module_used;
    logic [4:0]        word_slot;
    logic [PTR_W-1:0]  next0;
    logic [PTR_W-1:0]  next1;
    logic [PTR_W-1:0]  next2;
    logic [PTR_W-1:0]  next3;
    logic [MV_W-1:0]   match_vector;
  } out_beat_t;
endpackage

// ===== hw/rtl/bst_if.sv =====
// Valid/ready channel interfaces for input and result beats.
interface bst_in_if;
  import bst_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bst_out_if;
  import bst_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bit_split_trie_insert.sv =====
// Top level of the bit-split trie builder: sequencer, buffers and node store.
//
//   channel | dir | payload
//   in_ch   | in  | func, symbol, last, module_sel, tile_sel, node_idx
//   out_ch  | out | status, module_used, word_slot, next0..3, match_vector
//
// After reset a clearing pass writes every node entry to zero, one per cycle,
// MODULES*TILES*NODES entries (4096 by default); no beat is taken meanwhile.
// A non-final byte is stored in the byte buffer while it has room. A read
// registers its result from the read-data state. A final byte walks each
// buffered byte over each tile with one read-modify-write of the node store
// per step, each step going through S_W_RD, S_W_WAIT and S_W_MOD. A result
// waits in the output register until taken; the next beat is accepted only once it has gone.
module bit_split_trie_insert
  import bst_pkg::*;
#(
  parameter int MODULES = MODULES_DEF,
  parameter int NODES = NODES_DEF,
  parameter int MAX_WORD = MAX_WORD_DEF,
  parameter int WORDS_PER_MODULE = WORDS_PER_MODULE_DEF
) (
  input logic clk,
  input logic rst_n,
  bst_in_if.sink    in_ch,
  bst_out_if.source out_ch
);
  import bst_pkg::*;

  localparam int TILES = TILES_DEF;
  localparam int MW = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int NW = $clog2(NODES);
  localparam int DEPTH = MODULES * TILES * NODES;
  localparam int AW = $clog2(DEPTH);
  localparam int BW = $clog2(MAX_WORD + 1);
  localparam int BIW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CW = $clog2(WORDS_PER_MODULE + 1);
  localparam int EW = 4 * NW + WORDS_PER_MODULE;
  localparam int UW = MW + 2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD_DATA, S_PICK, S_W_RD, S_W_WAIT, S_W_MOD
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_r;
  logic [SYM_W-1:0]     buf_r [MAX_WORD];
  logic [BW-1:0]        cnt_r;
  logic                 overlong_r;
  logic [CW-1:0]        words_r [MODULES];
  logic [NW-1:0]        used_r [MODULES*TILES];
  logic [NW-1:0]        cur_r [TILES];
  logic [MW-1:0]        mod_r;
  logic [BW-1:0]        step_r;
  logic [1:0]           tile_r;
  logic                 rd_ok_r;
  logic                 ov_r;
  out_beat_t            out_r;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [AW-1:0]        cur_addr;
  logic [SYM_W-1:0]     cur_byte;
  logic [1:0]           part;
  logic [NW-1:0]        child;
  logic                 fin;
  logic [MW-1:0]        pick_m;
  logic                 pick_ok;

  bst_node_mem #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data = out_r;

  // Entry of the current walk step: module, tile, current node of that tile.
  assign cur_addr = AW'(({mod_r, tile_r} * NODES) + cur_r[tile_r]);
  assign cur_byte = buf_r[step_r[BIW-1:0]];
  assign part = 2'(cur_byte >> {tile_r, 1'b0});
  assign fin = (step_r + 1'b1) == cnt_r;
  assign child = rdata[(3 - part) * NW + WORDS_PER_MODULE +: NW];

  always_comb begin
    pick_m = '0;
    pick_ok = 1'b0;
    for (int m = MODULES - 1; m >= 0; m--) begin
      if (words_r[m] < CW'(WORDS_PER_MODULE)) begin
        pick_m = MW'(m);
        pick_ok = 1'b1;
      end
    end
  end

  // Entry layout: next0 at the top, match vector at the bottom.
  always_comb begin
    we = 1'b0;
    waddr = cur_addr;
    wdata = rdata;
    raddr = cur_addr;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (state_r == S_IDLE) begin
      raddr = AW'(({in_ch.data.module_sel[MW-1:0], in_ch.data.tile_sel} * NODES)
                  + in_ch.data.node_idx[NW-1:0]);
    end else if (state_r == S_W_MOD) begin
      if (fin) begin
        we = 1'b1;
        wdata[WORDS_PER_MODULE-1:0] = rdata[WORDS_PER_MODULE-1:0]
            | (WORDS_PER_MODULE'(1) << words_r[mod_r]);
      end else if (child == '0 && !(32'(used_r[{mod_r, tile_r}]) + 1 >= NODES)) begin
        we = 1'b1;
        wdata[(3 - part) * NW + WORDS_PER_MODULE +: NW] = used_r[{mod_r, tile_r}] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      overlong_r <= 1'b0;
      ov_r <= 1'b0;
      for (int m = 0; m < MODULES; m++) words_r[m] <= '0;
      for (int u = 0; u < MODULES * TILES; u++) used_r[u] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.data.func) begin
              out_r <= '0;
              rd_ok_r <= (32'(in_ch.data.module_sel) < MODULES)
                         && (32'(in_ch.data.node_idx) < NODES);
              state_r <= S_RD_DATA;
            end else begin
              if (cnt_r < BW'(MAX_WORD)) begin
                buf_r[cnt_r[BIW-1:0]] <= in_ch.data.symbol;
                cnt_r <= cnt_r + 1'b1;
              end
              if (in_ch.data.last) begin
                if (overlong_r || cnt_r >= BW'(MAX_WORD)) begin
                  out_r.status <= ST_TOO_LONG;
                  out_r.module_used <= '0;
                  out_r.word_slot <= '0;
                  out_r.next0 <= '0;
                  out_r.next1 <= '0;
                  out_r.next2 <= '0;
                  out_r.next3 <= '0;
                  out_r.match_vector <= '0;
                  ov_r <= 1'b1;
                  cnt_r <= '0;
                  overlong_r <= 1'b0;
                end else begin
                  out_r <= '0;
                  state_r <= S_PICK;
                end
              end else if (cnt_r >= BW'(MAX_WORD)) begin
                overlong_r <= 1'b1;
              end
            end
          end
        end
        S_RD_DATA: begin
          if (rd_ok_r) begin
            out_r.next0 <= PTR_W'(rdata[3*NW+WORDS_PER_MODULE +: NW]);
            out_r.next1 <= PTR_W'(rdata[2*NW+WORDS_PER_MODULE +: NW]);
            out_r.next2 <= PTR_W'(rdata[NW+WORDS_PER_MODULE +: NW]);
            out_r.next3 <= PTR_W'(rdata[WORDS_PER_MODULE +: NW]);
            out_r.match_vector <= MV_W'(rdata[WORDS_PER_MODULE-1:0]);
          end
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_PICK: begin
          if (!pick_ok) begin
            out_r.status <= ST_ALL_FULL;
            ov_r <= 1'b1;
            cnt_r <= '0;
            state_r <= S_IDLE;
          end else begin
            mod_r <= pick_m;
            out_r.module_used <= SEL_W'(pick_m);
            out_r.word_slot <= 5'(words_r[pick_m]);
            step_r <= '0;
            tile_r <= '0;
            for (int t = 0; t < TILES; t++) cur_r[t] <= '0;
            state_r <= S_W_RD;
          end
        end
        S_W_RD: state_r <= S_W_WAIT;
        S_W_WAIT: state_r <= S_W_MOD;
        S_W_MOD: begin
          tile_r <= tile_r + 1'b1;
          if (tile_r == 2'(TILES - 1)) step_r <= step_r + 1'b1;
          if (fin) begin
            // The final byte only marks match vectors; the word ends after the last tile.
            if (tile_r == 2'(TILES - 1)) begin
              words_r[mod_r] <= words_r[mod_r] + 1'b1;
              ov_r <= 1'b1;
              cnt_r <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_W_RD;
            end
          end else if (child == '0) begin
            if (32'(used_r[{mod_r, tile_r}]) + 1 >= NODES) begin
              out_r.status <= ST_NODES_FULL;
              ov_r <= 1'b1;
              cnt_r <= '0;
              state_r <= S_IDLE;
            end else begin
              used_r[{mod_r, tile_r}] <= used_r[{mod_r, tile_r}] + 1'b1;
              cur_r[tile_r] <= used_r[{mod_r, tile_r}] + 1'b1;
              state_r <= S_W_RD;
            end
          end else begin
            cur_r[tile_r] <= child;
            state_r <= S_W_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/bst_node_mem.sv =====
// Node store: one entry of four child pointers and a match vector per node.
module bst_node_mem #(
  parameter int DEPTH = 4096,
  parameter int AW = 12,
  parameter int DW = 56
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
